// ===== rtl/core/wavau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavau_pkg: shared types and constants of the WAVE / AU header parser
// Chunk identifiers, parse phases, result kinds and the payload layout.
// ----------------------------------------------------------------------------
package wavau_pkg;

	// Four-character chunk identifiers, first character in the top byte
	localparam logic [31:0] ID_RIFF  = 32'h52494646;
	localparam logic [31:0] ID_WAVE  = 32'h57415645;
	localparam logic [31:0] ID_FMT   = 32'h666d7420;
	localparam logic [31:0] ID_DATA  = 32'h64617461;
	localparam logic [31:0] ID_SND   = 32'h2e736e64;
	localparam logic [31:0] ID_INFO  = 32'h494e464f;
	localparam logic [31:0] ID_CSET  = 32'h43534554;
	localparam logic [31:0] ID_JUNK  = 32'h4a554e4b;
	localparam logic [31:0] ID_PAD   = 32'h50414420;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;

	// Byte positions of the last byte of each .au header word
	localparam logic [32:0] AU_OFFSET_IDX   = 33'd7;
	localparam logic [32:0] AU_SIZE_IDX     = 33'd11;
	localparam logic [32:0] AU_ENCODING_IDX = 33'd15;
	localparam logic [32:0] AU_RATE_IDX     = 33'd19;
	localparam logic [32:0] AU_CHANNELS_IDX = 33'd23;

	// Configuration port
	localparam int unsigned ADDR_W = 2;
	localparam logic [ADDR_W-1:0] REG_IGNORE_SIZE_LIMIT = 2'd0;

	// Payload widths
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned IN_USER_W  = 1;
	localparam int unsigned OUT_DATA_W = 112;
	localparam int unsigned OUT_USER_W = 2;

	typedef enum logic [3:0] {
		PH_ID        = 4'd0,
		PH_PRE_RIFF  = 4'd1,
		PH_PRE_OTHER = 4'd2,
		PH_PRE_SKIP  = 4'd3,
		PH_WAVE      = 4'd4,
		PH_SUB_ID    = 4'd5,
		PH_SZ_FMT    = 4'd6,
		PH_SZ_DATA   = 4'd7,
		PH_SZ_OTHER  = 4'd8,
		PH_FMT_BODY  = 4'd9,
		PH_SUB_SKIP  = 4'd10,
		PH_AU_HDR    = 4'd11,
		PH_AU_SKIP   = 4'd12,
		PH_PASS      = 4'd13,
		PH_REJECT    = 4'd14
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER   = 2'd0,
		KIND_AUDIO    = 2'd1,
		KIND_PAST_END = 2'd2,
		KIND_REJECTED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FMT_NONE = 2'd0,
		FMT_WAVE = 2'd1,
		FMT_AU   = 2'd2
	} format_t;

	// Input operation carried on tuser
	localparam logic OP_BYTE     = 1'b0;
	localparam logic OP_NEW_FILE = 1'b1;

endpackage : wavau_pkg
`default_nettype wire

// ===== rtl/core/wav_au_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wav_au_header_parser: streaming RIFF/WAVE and Sun .au header parser
// An audio file arrives one byte per item on the slave stream. The header is
// parsed in one forward pass and the PCM bytes that follow are passed on.
//
// Usage:
//  - Slave stream: tuser is the operation (0 next byte, 1 start a new file),
//    tdata the file byte. A new-file item clears the parse state and gives
//    no result; every byte item gives exactly one result.
//  - Master stream: tuser is the result kind, tdata the audio byte and the
//    header values parsed so far.
//  - An item is registered on entry in the input register and then handled by
//    the byte decoder and the parse state. Its result is loaded into the output
//    register when the item advances out of the input register and leaves the
//    block from there.
//  - One item is accepted every cycle unless the receiver stalls. The parse
//    state is updated as the decoder handles an item, so the next byte sees it.
//  - When the receiver stalls, the output register holds its result, the
//    input register holds the next item and tready falls once both are full.
//  - Reset clears both stream stages, the parse state and the size-limit
//    register. The size-limit register is written over the APB port.
// ----------------------------------------------------------------------------
module wav_au_header_parser (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Slave stream
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [7:0] file_byte
	input  wire logic [wavau_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] op
	input  wire logic [wavau_pkg::IN_USER_W-1:0]    s_axis_tuser,
	// Master stream
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [7:0] audio_byte, [9:8] format, [25:10] channel_count,
	// [57:26] samples_per_sec, [73:58] sample_bits, [74] big_endian,
	// [106:75] data_bytes, [111:107] zero
	output logic [wavau_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// [1:0] kind
	output logic [wavau_pkg::OUT_USER_W-1:0]        m_axis_tuser,
	// Configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [wavau_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);
	import wavau_pkg::*;

	// Configuration register
	logic ignore_size_limit_q;

	// Input stage
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// Parse state
	phase_t      phase_q;
	logic [32:0] position_q;
	logic [32:0] chunk_end_q;
	logic [32:0] wave_end_q;
	logic [31:0] assembly_word_q;
	logic        fmt_known_q;
	logic [31:0] au_data_offset_q;
	logic [1:0]  format_q;
	logic [15:0] channels_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic        msb_q;
	logic [31:0] size_q;
	logic [31:0] extracted_q;

	// Next parse state
	phase_t      phase_d;
	logic [32:0] position_d;
	logic [32:0] chunk_end_d;
	logic [32:0] wave_end_d;
	logic [31:0] assembly_word_d;
	logic        fmt_known_d;
	logic [31:0] au_data_offset_d;
	logic [1:0]  format_d;
	logic [15:0] channels_d;
	logic [31:0] rate_d;
	logic [15:0] bits_d;
	logic        msb_d;
	logic [31:0] size_d;
	logic [31:0] extracted_d;
	kind_t       kind_d;
	logic [7:0]  audio_d;

	// Byte decoder helpers
	logic [32:0] pos_inc;
	logic [32:0] pos_plus4;
	logic        field_done;
	logic [31:0] be_word;
	logic [31:0] le_word;
	logic [33:0] end_pre;
	logic [32:0] end_sub;
	logic [32:0] end_fmt;
	logic [3:0]  fmt_k;

	// Output register
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [7:0]  out_audio_q;
	logic [1:0]  out_format_q;
	logic [15:0] out_channels_q;
	logic [31:0] out_rate_q;
	logic [15:0] out_bits_q;
	logic        out_msb_q;
	logic [31:0] out_size_q;

	// APB access: always ready, register written in the access cycle
	assign pready = 1'b1;
	assign prdata = (paddr == REG_IGNORE_SIZE_LIMIT) ? {31'd0, ignore_size_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_size_limit_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == REG_IGNORE_SIZE_LIMIT)) begin
			ignore_size_limit_q <= pwdata[0];
		end
	end

	// Stream handshake: a new-file item leaves without a result slot
	assign advance       = valid_s1 && ((op_s1 == OP_NEW_FILE) || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	// Field assembly and end-of-field arithmetic
	assign pos_inc    = position_q + 33'd1;
	assign pos_plus4  = position_q + 33'd5;
	assign field_done = (pos_inc == chunk_end_q);
	assign be_word    = {assembly_word_q[23:0], byte_s1};
	assign le_word    = {byte_s1, assembly_word_q[31:8]};
	assign end_pre    = {1'b0, pos_inc} + {2'b00, le_word};
	assign end_sub    = pos_inc + {1'b0, le_word};
	assign end_fmt    = pos_inc - 33'd16 + {1'b0, assembly_word_q};
	// Offset of this byte within the 16-byte fmt body
	assign fmt_k      = position_q[3:0] - chunk_end_q[3:0];

	// Byte decoder: one header, audio, past-end or rejected byte per cycle, unless stalled
	always_comb begin
		phase_d          = phase_q;
		position_d       = position_q;
		chunk_end_d      = chunk_end_q;
		wave_end_d       = wave_end_q;
		assembly_word_d  = assembly_word_q;
		fmt_known_d      = fmt_known_q;
		au_data_offset_d = au_data_offset_q;
		format_d         = format_q;
		channels_d       = channels_q;
		rate_d           = rate_q;
		bits_d           = bits_q;
		msb_d            = msb_q;
		size_d           = size_q;
		extracted_d      = extracted_q;
		kind_d           = KIND_HEADER;
		audio_d          = 8'd0;

		case (phase_q)
			PH_REJECT: begin
				kind_d = KIND_REJECTED;
			end
			PH_PASS: begin
				if ((size_q != 32'd0) && !ignore_size_limit_q && (extracted_q >= size_q)) begin
					kind_d = KIND_PAST_END;
				end else begin
					kind_d  = KIND_AUDIO;
					audio_d = byte_s1;
					if (extracted_q != ALL_ONES) begin
						extracted_d = extracted_q + 32'd1;
					end
				end
			end
			PH_ID: begin
				position_d      = pos_inc;
				assembly_word_d = be_word;
				if (field_done) begin
					chunk_end_d = pos_plus4;
					if ((pos_inc == 33'd4) && (be_word == ID_SND)) begin
						format_d = FMT_AU;
						msb_d    = 1'b1;
						phase_d  = PH_AU_HDR;
					end else if (be_word == ID_RIFF) begin
						phase_d = PH_PRE_RIFF;
					end else if ((be_word == ID_INFO) || (be_word == ID_CSET) ||
							(be_word == ID_JUNK) || (be_word == ID_PAD)) begin
						phase_d = PH_PRE_OTHER;
					end else begin
						phase_d = PH_REJECT;
					end
				end
			end
			PH_PRE_RIFF, PH_PRE_OTHER: begin
				position_d      = pos_inc;
				assembly_word_d = le_word;
				if (field_done) begin
					if ((end_pre > {2'b00, ALL_ONES}) || (le_word < 32'd4)) begin
						phase_d = PH_REJECT;
					end else if (phase_q == PH_PRE_RIFF) begin
						wave_end_d  = end_pre[32:0];
						chunk_end_d = pos_plus4;
						phase_d     = PH_WAVE;
					end else begin
						chunk_end_d = end_pre[32:0];
						phase_d     = PH_PRE_SKIP;
					end
				end
			end
			PH_PRE_SKIP: begin
				position_d = pos_inc;
				if (field_done) begin
					phase_d     = PH_ID;
					chunk_end_d = pos_plus4;
				end
			end
			PH_WAVE: begin
				position_d      = pos_inc;
				assembly_word_d = be_word;
				if (field_done) begin
					if ((be_word != ID_WAVE) || (pos_inc >= wave_end_q)) begin
						phase_d = PH_REJECT;
					end else begin
						phase_d     = PH_SUB_ID;
						chunk_end_d = pos_plus4;
					end
				end
			end
			PH_SUB_ID: begin
				position_d      = pos_inc;
				assembly_word_d = be_word;
				if (field_done) begin
					chunk_end_d = pos_plus4;
					if (be_word == ID_FMT) begin
						phase_d = PH_SZ_FMT;
					end else if (be_word == ID_DATA) begin
						phase_d = fmt_known_q ? PH_SZ_DATA : PH_REJECT;
					end else begin
						phase_d = PH_SZ_OTHER;
					end
				end
			end
			PH_SZ_FMT: begin
				position_d      = pos_inc;
				assembly_word_d = le_word;
				if (field_done) begin
					if (le_word < 32'd16) begin
						phase_d = PH_REJECT;
					end else begin
						chunk_end_d = pos_inc + 33'd16;
						phase_d     = PH_FMT_BODY;
					end
				end
			end
			PH_SZ_DATA: begin
				position_d      = pos_inc;
				assembly_word_d = le_word;
				if (field_done) begin
					size_d      = le_word;
					format_d    = FMT_WAVE;
					extracted_d = 32'd0;
					phase_d     = PH_PASS;
				end
			end
			PH_SZ_OTHER: begin
				position_d      = pos_inc;
				assembly_word_d = le_word;
				// Skip an unknown subchunk, unless the RIFF chunk is exhausted
				if (field_done) begin
					if (pos_inc >= wave_end_q) begin
						phase_d = PH_REJECT;
					end else if (end_sub <= pos_inc) begin
						chunk_end_d = pos_plus4;
						phase_d     = PH_SUB_ID;
					end else begin
						chunk_end_d = end_sub;
						phase_d     = PH_SUB_SKIP;
					end
				end
			end
			PH_FMT_BODY: begin
				position_d = pos_inc;
				// The format word must read linear PCM
				if (((fmt_k == 4'd0) && (byte_s1 != 8'd1)) ||
						((fmt_k == 4'd1) && (byte_s1 != 8'd0))) begin
					phase_d = PH_REJECT;
				end else begin
					case (fmt_k)
						4'd2:    channels_d[7:0]  = byte_s1;
						4'd3:    channels_d[15:8] = byte_s1;
						4'd4:    rate_d[7:0]      = byte_s1;
						4'd5:    rate_d[15:8]     = byte_s1;
						4'd6:    rate_d[23:16]    = byte_s1;
						4'd7:    rate_d[31:24]    = byte_s1;
						4'd14:   bits_d[7:0]      = byte_s1;
						4'd15:   bits_d[15:8]     = byte_s1;
						default: ;
					endcase
					if (field_done) begin
						msb_d       = 1'b0;
						fmt_known_d = 1'b1;
						if (pos_inc >= wave_end_q) begin
							phase_d = PH_REJECT;
						end else if (end_fmt <= pos_inc) begin
							chunk_end_d = pos_plus4;
							phase_d     = PH_SUB_ID;
						end else begin
							chunk_end_d = end_fmt;
							phase_d     = PH_SUB_SKIP;
						end
					end
				end
			end
			PH_SUB_SKIP: begin
				position_d = pos_inc;
				if (field_done) begin
					chunk_end_d = pos_plus4;
					phase_d     = PH_SUB_ID;
				end
			end
			PH_AU_HDR: begin
				position_d      = pos_inc;
				assembly_word_d = be_word;
				// Each .au header word is taken when its last byte arrives
				if (position_q == AU_OFFSET_IDX) begin
					au_data_offset_d = be_word;
				end else if (position_q == AU_SIZE_IDX) begin
					size_d = (be_word == ALL_ONES) ? 32'd0 : be_word;
				end else if (position_q == AU_ENCODING_IDX) begin
					if ((be_word >= 32'd2) && (be_word <= 32'd5)) begin
						bits_d = {10'd0, be_word[2:0] - 3'd1, 3'd0};
					end else begin
						phase_d = PH_REJECT;
					end
				end else if (position_q == AU_RATE_IDX) begin
					rate_d = be_word;
				end else if (position_q == AU_CHANNELS_IDX) begin
					channels_d  = (be_word[31:16] != 16'd0) ? 16'hffff : be_word[15:0];
					extracted_d = 32'd0;
					phase_d     = ({1'b0, au_data_offset_q} <= pos_inc) ? PH_PASS : PH_AU_SKIP;
				end
			end
			PH_AU_SKIP: begin
				position_d = pos_inc;
				if (pos_inc >= {1'b0, au_data_offset_q}) begin
					phase_d = PH_PASS;
				end
			end
			default: begin
				position_d = pos_inc;
				phase_d    = PH_REJECT;
			end
		endcase

		if (phase_d == PH_REJECT) begin
			kind_d = KIND_REJECTED;
		end
	end

	// Parse state: a new-file item restores the reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_ID;
			position_q       <= 33'd0;
			chunk_end_q      <= 33'd4;
			wave_end_q       <= 33'd0;
			assembly_word_q  <= 32'd0;
			fmt_known_q      <= 1'b0;
			au_data_offset_q <= 32'd0;
			format_q         <= FMT_NONE;
			channels_q       <= 16'd0;
			rate_q           <= 32'd0;
			bits_q           <= 16'd0;
			msb_q            <= 1'b0;
			size_q           <= 32'd0;
			extracted_q      <= 32'd0;
		end else if (advance) begin
			if (op_s1 == OP_NEW_FILE) begin
				phase_q          <= PH_ID;
				position_q       <= 33'd0;
				chunk_end_q      <= 33'd4;
				wave_end_q       <= 33'd0;
				assembly_word_q  <= 32'd0;
				fmt_known_q      <= 1'b0;
				au_data_offset_q <= 32'd0;
				format_q         <= FMT_NONE;
				channels_q       <= 16'd0;
				rate_q           <= 32'd0;
				bits_q           <= 16'd0;
				msb_q            <= 1'b0;
				size_q           <= 32'd0;
				extracted_q      <= 32'd0;
			end else begin
				phase_q          <= phase_d;
				position_q       <= position_d;
				chunk_end_q      <= chunk_end_d;
				wave_end_q       <= wave_end_d;
				assembly_word_q  <= assembly_word_d;
				fmt_known_q      <= fmt_known_d;
				au_data_offset_q <= au_data_offset_d;
				format_q         <= format_d;
				channels_q       <= channels_d;
				rate_q           <= rate_d;
				bits_q           <= bits_d;
				msb_q            <= msb_d;
				size_q           <= size_d;
				extracted_q      <= extracted_d;
			end
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (op_s1 == OP_BYTE)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance && (op_s1 == OP_BYTE)) begin
			out_kind_q     <= kind_d;
			out_audio_q    <= audio_d;
			out_format_q   <= format_d;
			out_channels_q <= channels_d;
			out_rate_q     <= rate_d;
			out_bits_q     <= bits_d;
			out_msb_q      <= msb_d;
			out_size_q     <= size_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {5'd0, out_size_q, out_msb_q, out_bits_q, out_rate_q,
		out_channels_q, out_format_q, out_audio_q};

endmodule : wav_au_header_parser
`default_nettype wire

// ===== sim/parse_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parse_check_pkg: result checker for the WAVE / AU header parser
// Holds a bit-accurate copy of the header parse and the queue of results it
// predicts. Every accepted input item is run through the copy, and every
// result leaving the block is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
package parse_check_pkg;
	import wavau_pkg::*;

	// One predicted result, field for field as the block reports it
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  audio;
		format_t     fmt;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
		logic        msb;
		logic [31:0] size;
	} parse_result_t;

	class parse_scoreboard;
		bit              limit_off;
		int unsigned     errors;
		parse_result_t   expected_q[$];

		// Parse state of the current file
		phase_t          phase;
		logic [32:0]     pos;
		logic [32:0]     chunk_end;
		logic [32:0]     wave_end;
		logic [31:0]     word;
		logic [31:0]     au_offset;
		logic            fmt_known;
		format_t         fmt;
		logic [15:0]     channels;
		logic [31:0]     rate;
		logic [15:0]     bits;
		logic            msb;
		logic [31:0]     size;
		logic [31:0]     extracted;

		function new();
			limit_off = 1'b0;
			errors    = 0;
			clear_file();
		endfunction

		// A new file clears everything but the size-limit register.
		function void clear_file();
			phase     = PH_ID;
			pos       = '0;
			chunk_end = 33'd4;
			wave_end  = '0;
			word      = '0;
			au_offset = '0;
			fmt_known = 1'b0;
			fmt       = FMT_NONE;
			channels  = '0;
			rate      = '0;
			bits      = '0;
			msb       = 1'b0;
			size      = '0;
			extracted = '0;
		endfunction

		function void enter_sub_id();
			phase     = PH_SUB_ID;
			chunk_end = pos + 33'd4;
		endfunction

		// After a subchunk header or the fmt body: the RIFF end must lie
		// ahead, then the rest of the subchunk is skipped.
		function void close_part(logic [32:0] end_at);
			if (pos >= wave_end) begin
				phase = PH_REJECT;
				return;
			end
			chunk_end = end_at;
			if (chunk_end <= pos)
				enter_sub_id();
			else
				phase = PH_SUB_SKIP;
		endfunction

		// One header byte; returns the kind that it answers with.
		function kind_t header_byte(logic [7:0] b);
			logic [31:0] be;
			logic [31:0] le;
			logic [32:0] idx;
			logic [32:0] end_at;
			logic [33:0] end_wide;
			logic [32:0] k;
			logic [31:0] wide_bits;
			logic        done;
			be   = {word[23:0], b};
			le   = {b, word[31:8]};
			idx  = pos;
			pos  = pos + 33'd1;
			done = (pos == chunk_end);
			case (phase)
				PH_ID: begin
					word = be;
					if (done) begin
						chunk_end = pos + 33'd4;
						if (pos == 33'd4 && be == ID_SND) begin
							fmt   = FMT_AU;
							msb   = 1'b1;
							phase = PH_AU_HDR;
						end else if (be == ID_RIFF) begin
							phase = PH_PRE_RIFF;
						end else if (be == ID_INFO || be == ID_CSET || be == ID_JUNK ||
								be == ID_PAD) begin
							phase = PH_PRE_OTHER;
						end else begin
							phase = PH_REJECT;
						end
					end
				end
				PH_PRE_RIFF, PH_PRE_OTHER: begin
					word = le;
					if (done) begin
						// The sum can pass 33 bits after a long leading chunk
						end_wide = {1'b0, pos} + {2'b00, le};
						end_at   = end_wide[32:0];
						if (end_wide > {2'b00, ALL_ONES} || le < 32'd4) begin
							phase = PH_REJECT;
						end else if (phase == PH_PRE_RIFF) begin
							wave_end  = end_at;
							chunk_end = pos + 33'd4;
							phase     = PH_WAVE;
						end else begin
							chunk_end = end_at;
							phase     = PH_PRE_SKIP;
						end
					end
				end
				PH_PRE_SKIP: begin
					if (done) begin
						phase     = PH_ID;
						chunk_end = pos + 33'd4;
					end
				end
				PH_WAVE: begin
					word = be;
					if (done) begin
						if (be != ID_WAVE || pos >= wave_end)
							phase = PH_REJECT;
						else
							enter_sub_id();
					end
				end
				PH_SUB_ID: begin
					word = be;
					if (done) begin
						chunk_end = pos + 33'd4;
						if (be == ID_FMT)
							phase = PH_SZ_FMT;
						else if (be == ID_DATA)
							phase = fmt_known ? PH_SZ_DATA : PH_REJECT;
						else
							phase = PH_SZ_OTHER;
					end
				end
				PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
					word = le;
					if (done) begin
						if (phase == PH_SZ_FMT) begin
							if (le < 32'd16) begin
								phase = PH_REJECT;
							end else begin
								chunk_end = pos + 33'd16;
								phase     = PH_FMT_BODY;
							end
						end else if (phase == PH_SZ_DATA) begin
							size      = le;
							fmt       = FMT_WAVE;
							extracted = '0;
							phase     = PH_PASS;
						end else begin
							close_part(pos + {1'b0, le});
						end
					end
				end
				PH_FMT_BODY: begin
					// Offset of this byte within the 16-byte fmt body
					k = 33'd16 - (chunk_end - idx);
					if ((k == 33'd0 && b != 8'd1) || (k == 33'd1 && b != 8'd0)) begin
						phase = PH_REJECT;
					end else begin
						case (k[3:0])
							4'd2:  channels[7:0]  = b;
							4'd3:  channels[15:8] = b;
							4'd4:  rate[7:0]      = b;
							4'd5:  rate[15:8]     = b;
							4'd6:  rate[23:16]    = b;
							4'd7:  rate[31:24]    = b;
							4'd14: bits[7:0]      = b;
							4'd15: bits[15:8]     = b;
							default: ;
						endcase
						if (done) begin
							msb       = 1'b0;
							fmt_known = 1'b1;
							// word still holds the declared fmt size
							close_part(pos - 33'd16 + {1'b0, word});
						end
					end
				end
				PH_SUB_SKIP: begin
					if (done)
						enter_sub_id();
				end
				PH_AU_HDR: begin
					word = be;
					if (idx == AU_OFFSET_IDX) begin
						au_offset = be;
					end else if (idx == AU_SIZE_IDX) begin
						size = (be == ALL_ONES) ? 32'd0 : be;
					end else if (idx == AU_ENCODING_IDX) begin
						if (be >= 32'd2 && be <= 32'd5) begin
							wide_bits = (be - 32'd1) << 3;
							bits      = wide_bits[15:0];
						end else begin
							phase = PH_REJECT;
						end
					end else if (idx == AU_RATE_IDX) begin
						rate = be;
					end else if (idx == AU_CHANNELS_IDX) begin
						channels  = (be > 32'h0000ffff) ? 16'hffff : be[15:0];
						extracted = '0;
						phase     = ({1'b0, au_offset} <= pos) ? PH_PASS : PH_AU_SKIP;
					end
				end
				PH_AU_SKIP: begin
					if (pos >= {1'b0, au_offset})
						phase = PH_PASS;
				end
				default: phase = PH_REJECT;
			endcase
			return (phase == PH_REJECT) ? KIND_REJECTED : KIND_HEADER;
		endfunction

		// An accepted input item: a byte queues one predicted result.
		function void note_item(logic op, logic [7:0] b);
			parse_result_t r;
			if (op == OP_NEW_FILE) begin
				clear_file();
				return;
			end
			r = '0;
			if (phase == PH_REJECT) begin
				r.kind = KIND_REJECTED;
			end else if (phase == PH_PASS) begin
				if (size != 32'd0 && !limit_off && extracted >= size) begin
					r.kind = KIND_PAST_END;
				end else begin
					r.kind  = KIND_AUDIO;
					r.audio = b;
					if (extracted != ALL_ONES)
						extracted = extracted + 32'd1;
				end
			end else begin
				r.kind = header_byte(b);
			end
			r.fmt      = fmt;
			r.channels = channels;
			r.rate     = rate;
			r.bits     = bits;
			r.msb      = msb;
			r.size     = size;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		// An accepted result, checked against the oldest prediction.
		function void check_item(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
			parse_result_t want;
			if (expected_q.size() == 0) begin
				$error("result of kind %0d with no byte item outstanding", user);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", want.kind, user);
			compare_field("audio_byte", want.audio, data[7:0]);
			compare_field("format", want.fmt, data[9:8]);
			compare_field("channel_count", want.channels, data[25:10]);
			compare_field("samples_per_sec", want.rate, data[57:26]);
			compare_field("sample_bits", want.bits, data[73:58]);
			compare_field("big_endian", want.msb, data[74]);
			compare_field("data_bytes", want.size, data[106:75]);
		endfunction
	endclass

endpackage : parse_check_pkg

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream test of the WAVE / AU header parser
// Feeds whole audio files byte by byte, mostly well-formed RIFF/WAVE and .au
// headers with random content, and some with one deliberate flaw, noise or a
// flipped byte. Both stream sides stall at random and the size-limit register
// is changed between phases. Results are checked by the scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
	import wavau_pkg::*;
	import parse_check_pkg::*;

	// The one defect, if any, that a generated file carries
	typedef enum {
		FLAW_NONE,
		FLAW_LEAD_ID,
		FLAW_LEAD_SIZE,
		FLAW_DATA_FIRST,
		FLAW_SHORT_FMT,
		FLAW_FMT_WORD,
		FLAW_RIFF_SHORT,
		FLAW_AU_ENCODING,
		FLAW_NOISE,
		FLAW_FLIP
	} file_flaw_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [ADDR_W-1:0]     paddr         = '0;
	logic [31:0]           pwdata        = '0;
	logic [31:0]           prdata;
	logic                  pready;

	logic                  calm          = 1'b0;
	int unsigned           items_sent    = 0;
	logic [7:0]            file_q[$];
	parse_scoreboard       sb;

	wav_au_header_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver stalls at random outside the calm stretch.
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
	end

	// Both handshakes are sampled with the values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tuser[0], s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_item(m_axis_tuser, m_axis_tdata);
		end
	end

	// Present one item, with random idle cycles ahead of it.
	task automatic send_item(input logic op, input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Register write: setup cycle, then access until pready.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.limit_off = value[0];
	endtask

	// Stop sending, let every result out, then a few more cycles for a
	// trailing new-file item that gives no result.
	task automatic drain();
		int unsigned waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic void push_be(input logic [31:0] w);
		file_q.push_back(w[31:24]);
		file_q.push_back(w[23:16]);
		file_q.push_back(w[15:8]);
		file_q.push_back(w[7:0]);
	endfunction

	function automatic void push_le(input logic [31:0] w);
		file_q.push_back(w[7:0]);
		file_q.push_back(w[15:8]);
		file_q.push_back(w[23:16]);
		file_q.push_back(w[31:24]);
	endfunction

	function automatic void push_random(input int unsigned n);
		repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// A chunk size that is either below four or runs past 4 GiB.
	function automatic logic [31:0] bad_length();
		if ($urandom_range(0, 1))
			return 32'($urandom_range(0, 3));
		return ALL_ONES - 32'($urandom_range(0, 7));
	endfunction

	// Unknown subchunk; its id starts with 'L' so it is never fmt or data.
	function automatic void push_skip_chunk();
		int unsigned len;
		len = $urandom_range(0, 10);
		push_be({8'h4c, 24'($urandom)});
		push_le(len);
		push_random(len);
	endfunction

	function automatic void build_wave(input file_flaw_t flaw);
		int unsigned n_lead;
		int unsigned bad_lead;
		int unsigned len;
		logic [31:0] riff_len;
		logic [31:0] fmt_len;
		logic [31:0] data_len;
		logic [15:0] fmt_word;
		n_lead   = $urandom_range(0, 2);
		bad_lead = (flaw == FLAW_LEAD_SIZE) ? $urandom_range(0, 1) : 0;
		// Chunks tolerated ahead of RIFF, the last one possibly bad in size
		for (int i = 0; i < n_lead + bad_lead; i++) begin
			case ($urandom_range(0, 3))
				0:       push_be(ID_INFO);
				1:       push_be(ID_CSET);
				2:       push_be(ID_JUNK);
				default: push_be(ID_PAD);
			endcase
			if (i == n_lead) begin
				push_le(bad_length());
			end else begin
				len = $urandom_range(4, 12);
				push_le(len);
				push_random(len);
			end
		end
		// Unknown leading id, or .snd anywhere but at the start
		if (flaw == FLAW_LEAD_ID)
			push_be((n_lead > 0 && $urandom_range(0, 1)) ? ID_SND : $urandom);
		push_be(ID_RIFF);
		if (flaw == FLAW_LEAD_SIZE && bad_lead == 0)
			riff_len = bad_length();
		else if (flaw == FLAW_RIFF_SHORT)
			riff_len = $urandom_range(4, 40);
		else
			riff_len = 32'h0010_0000 + 32'($urandom_range(0, 32'h000f_ffff));
		push_le(riff_len);
		push_be(ID_WAVE);
		if ($urandom_range(0, 2) == 0)
			push_skip_chunk();
		if (flaw == FLAW_DATA_FIRST) begin
			len = $urandom_range(0, 20);
			push_be(ID_DATA);
			push_le(len);
			push_random(len);
		end
		// fmt subchunk: linear PCM unless the format word is spoilt
		push_be(ID_FMT);
		if (flaw == FLAW_SHORT_FMT)
			fmt_len = $urandom_range(0, 15);
		else
			fmt_len = $urandom_range(0, 1) ? 32'd16 : 32'($urandom_range(17, 22));
		push_le(fmt_len);
		if (flaw == FLAW_FMT_WORD)
			fmt_word = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
		else
			fmt_word = 16'd1;
		file_q.push_back(fmt_word[7:0]);
		file_q.push_back(fmt_word[15:8]);
		push_random(14);
		if (fmt_len > 32'd16)
			push_random(fmt_len - 32'd16);
		if ($urandom_range(0, 2) == 0)
			push_skip_chunk();
		// data subchunk and its samples, a little past the declared end
		push_be(ID_DATA);
		case ($urandom_range(0, 3))
			0:       data_len = 32'd0;
			3:       data_len = ALL_ONES - 32'($urandom_range(0, 255));
			default: data_len = $urandom_range(1, 40);
		endcase
		push_le(data_len);
		if (data_len != 32'd0 && data_len <= 32'd40)
			push_random(data_len + $urandom_range(0, 6));
		else
			push_random($urandom_range(0, 40));
	endfunction

	function automatic void build_au(input file_flaw_t flaw);
		logic [31:0] offset;
		logic [31:0] data_len;
		logic [31:0] encoding;
		push_be(ID_SND);
		case ($urandom_range(0, 2))
			0:       offset = $urandom_range(0, 23);
			1:       offset = 32'd24;
			default: offset = $urandom_range(25, 48);
		endcase
		push_be(offset);
		case ($urandom_range(0, 3))
			0:       data_len = ALL_ONES;
			1:       data_len = 32'd0;
			default: data_len = $urandom_range(1, 40);
		endcase
		push_be(data_len);
		if (flaw == FLAW_AU_ENCODING) begin
			case ($urandom_range(0, 3))
				0:       encoding = 32'd0;
				1:       encoding = 32'd1;
				2:       encoding = 32'd6;
				default: encoding = $urandom;
			endcase
		end else begin
			encoding = $urandom_range(2, 5);
		end
		push_be(encoding);
		push_be($urandom);
		// Channel counts past 65535 saturate
		push_be($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 8)));
		if (offset > 32'd24)
			push_random(offset - 32'd24);
		if (data_len != 32'd0 && data_len <= 32'd40)
			push_random(data_len + $urandom_range(0, 6));
		else
			push_random($urandom_range(0, 40));
	endfunction

	// Build one file and send it, usually after a new-file item.
	task automatic send_file(input file_flaw_t flaw, input bit as_au);
		int unsigned spot;
		file_q = {};
		if (flaw == FLAW_NOISE)
			push_random($urandom_range(4, 30));
		else if (as_au || flaw == FLAW_AU_ENCODING)
			build_au(flaw);
		else
			build_wave(flaw);
		if (flaw == FLAW_FLIP) begin
			spot = $urandom_range(0, file_q.size() - 1);
			file_q[spot] = file_q[spot] ^ 8'($urandom_range(1, 255));
		end
		if ($urandom_range(0, 7) != 0)
			send_item(OP_NEW_FILE, 8'($urandom_range(0, 255)));
		foreach (file_q[i])
			send_item(OP_BYTE, file_q[i]);
	endtask

	// Main sequence
	initial begin
		logic [8:0]  opening[$];
		int unsigned phase_start;
		file_flaw_t  flaw;
		sb = new();
		// Unknown leading id held rejected, a leading size below four,
		// then the start of an .au header
		opening = '{
			{OP_NEW_FILE, 8'hff},
			{OP_BYTE, 8'h00}, {OP_BYTE, 8'hff}, {OP_BYTE, 8'h41}, {OP_BYTE, 8'h42},
			{OP_BYTE, 8'hff}, {OP_BYTE, 8'h00},
			{OP_NEW_FILE, 8'h00},
			{OP_BYTE, 8'h4a}, {OP_BYTE, 8'h55}, {OP_BYTE, 8'h4e}, {OP_BYTE, 8'h4b},
			{OP_BYTE, 8'h03}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h00},
			{OP_NEW_FILE, 8'h5a},
			{OP_BYTE, 8'h2e}, {OP_BYTE, 8'h73}, {OP_BYTE, 8'h6e}, {OP_BYTE, 8'h64}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_IGNORE_SIZE_LIMIT, 32'd0);
		foreach (opening[i])
			send_item(opening[i][8], opening[i][7:0]);

		// Random files in three phases of the size-limit setting
		for (int p = 0; p < 3; p++) begin
			drain();
			write_reg(REG_IGNORE_SIZE_LIMIT, {31'($urandom), (p != 1)});
			phase_start = items_sent;
			while (items_sent < phase_start + 330) begin
				// The first half of the middle phase runs without stalls
				calm <= (p == 1) && (items_sent < phase_start + 165);
				if ($urandom_range(0, 99) < 55)
					flaw = FLAW_NONE;
				else
					flaw = file_flaw_t'($urandom_range(1, 9));
				send_file(flaw, $urandom_range(0, 2) == 0);
			end
		end
		calm <= 1'b0;
		drain();
		if (sb.expected_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#(3_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule : testbench

// ===== filelist.f =====
rtl/core/wavau_pkg.sv
rtl/core/wav_au_header_parser.sv
sim/parse_check_pkg.sv
sim/testbench.sv
